// ===== rtl/scx_pkg.sv =====
`timescale 1ns / 1ps
package scx_pkg;
  localparam int RES_W   = 16;
  localparam int ANG_W   = 16;
  localparam int D2_W    = 32;
  localparam int ENT_W   = 16;
  localparam int TRIG_W  = 17;
  localparam int VEC_W   = 32;
  localparam int PP_W    = 64;
  localparam int COV_W   = 34;
  localparam int DIAG_W  = 33;
  localparam int NTERM   = 6;
  localparam int QUARTER = 16384;

  // row and column of each lower-triangle term: xx, yx, yy, zx, zy, zz
  localparam logic [1:0] ROW_IDX [0:NTERM-1] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] COL_IDX [0:NTERM-1] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};

  typedef logic [D2_W-1:0]         d2_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [PP_W-1:0]  pp_t;
  typedef logic signed [COV_W-1:0] cov_t;
endpackage

// ===== rtl/scx_sine_rom.sv =====
`timescale 1ns / 1ps
module scx_sine_rom #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int AW = $clog2(SINE_TABLE_ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [AW-1:0]            addr_a,
  input  logic [AW-1:0]            addr_b,
  output logic [scx_pkg::ENT_W-1:0] data_a_r,
  output logic [scx_pkg::ENT_W-1:0] data_b_r
);
  import scx_pkg::*;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SER_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  typedef logic [ENT_W-1:0] tbl_t [0:SINE_TABLE_ENTRIES];

  // quarter-wave sine in Q1.15 from a Q30 Taylor series
  function automatic tbl_t build_table();
    tbl_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q15;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x = (64'(k) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / SER_DIV[n];
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q15 = (sum + 64'd16384) >> 15;
      if (q15 > 64'd32768) begin
        q15 = 64'd32768;
      end
      t[k] = ENT_W'(q15);
    end
    return t;
  endfunction

  localparam tbl_t SINE_TBL = build_table();

  // read both ports, hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= SINE_TBL[addr_a];
      data_b_r <= SINE_TBL[addr_b];
    end
  end
endmodule

// ===== rtl/scx_term.sv =====
`timescale 1ns / 1ps
module scx_term (
  input  logic          clk,
  input  logic          en,
  input  scx_pkg::d2_t  d2u,
  input  scx_pkg::d2_t  d2v,
  input  scx_pkg::pp_t  pu,
  input  scx_pkg::pp_t  pv,
  output scx_pkg::cov_t cov_r
);
  import scx_pkg::*;

  localparam int HI_W  = PP_W - 30;
  localparam int HP_W  = D2_W + 1 + HI_W;
  localparam int LP_W  = D2_W + 30;
  localparam int TW    = 100;

  logic signed [HI_W-1:0] hi_u;
  logic signed [HI_W-1:0] hi_v;
  logic signed [HP_W-1:0] hiu_r;
  logic signed [HP_W-1:0] hiv_r;
  logic [LP_W-1:0]        lou_r;
  logic [LP_W-1:0]        lov_r;
  logic signed [TW-1:0]   hsum;
  logic signed [TW-1:0]   lsum;
  logic signed [TW-1:0]   total;

  // split each pair product into a floored high part and a 30-bit low part
  assign hi_u = signed'(pu[PP_W-1:30]);
  assign hi_v = signed'(pv[PP_W-1:30]);

  always_ff @(posedge clk) begin
    if (en) begin
      hiu_r <= signed'({1'b0, d2u}) * hi_u;
      hiv_r <= signed'({1'b0, d2v}) * hi_v;
      lou_r <= LP_W'(d2u) * LP_W'(pu[29:0]);
      lov_r <= LP_W'(d2v) * LP_W'(pv[29:0]);
    end
  end

  // add the halves with a half-unit bias, then floor to 2^-32 mm^2
  always_comb begin
    hsum  = (TW'(hiu_r) + TW'(hiv_r)) <<< 30;
    lsum  = signed'(TW'(lou_r)) + signed'(TW'(lov_r));
    total = hsum + lsum + (TW'(1) <<< 59);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov_r <= COV_W'(total >>> 60);
    end
  end
endmodule

// ===== rtl/strip_covariance_to_xyz.sv =====
`timescale 1ns / 1ps
// Strip covariance to xyz.
// Input channel (in_valid/in_ready): two strip directions per word, each as
// polar and azimuth binary angles plus a Q0.16 mm resolution.
// Output channel (out_valid/out_ready): the lower triangle of
// dU^2 u u^T + dV^2 v v^T as cov_xx, cov_yx, cov_yy, cov_zx, cov_zy, cov_zz
// in units of 2^-32 mm^2, rounded to nearest.
// Six register stages: index, sine ROM read, vector products, pair products,
// resolution partial products, final sum; out_valid is the final-sum valid bit.
// Throughput is one word per cycle unless a finished word is held at the output;
// the four dual-port sine ROMs serve all eight lookups.
// The whole pipe advances together; when the receiver holds out_ready low
// with a word waiting, in_ready drops and every stage holds its contents.
// Reset clears all stage valid bits; the output goes idle on the next cycle.
module strip_covariance_to_xyz #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [scx_pkg::RES_W-1:0]         in_res_u,
  input  logic [scx_pkg::ANG_W-1:0]         in_polar_u,
  input  logic [scx_pkg::ANG_W-1:0]         in_azimuth_u,
  input  logic [scx_pkg::RES_W-1:0]         in_res_v,
  input  logic [scx_pkg::ANG_W-1:0]         in_polar_v,
  input  logic [scx_pkg::ANG_W-1:0]         in_azimuth_v,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [scx_pkg::DIAG_W-1:0]        out_cov_xx,
  output logic signed [scx_pkg::COV_W-1:0]  out_cov_yx,
  output logic [scx_pkg::DIAG_W-1:0]        out_cov_yy,
  output logic signed [scx_pkg::COV_W-1:0]  out_cov_zx,
  output logic signed [scx_pkg::COV_W-1:0]  out_cov_zy,
  output logic [scx_pkg::DIAG_W-1:0]        out_cov_zz
);
  import scx_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PW = 15 + AW;

  logic              en;
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [ANG_W-1:0]  ang [0:7];
  logic [AW-1:0]     idx_r [0:7];
  logic              neg1_r [0:7];
  logic              neg2_r [0:7];
  logic [ENT_W-1:0]  ent [0:7];
  logic signed [TRIG_W-1:0] trig [0:7];
  d2_t               d2u1_r, d2v1_r, d2u2_r, d2v2_r, d2u3_r, d2v3_r, d2u4_r, d2v4_r;
  vec_t              vec3_r [0:1][0:2];
  pp_t               pp4_r [0:1][0:NTERM-1];
  cov_t              cov [0:NTERM-1];

  // table index for the quadrant, mirrored on odd quadrants
  function automatic logic [AW-1:0] quad_index(input logic [ANG_W-1:0] a);
    logic [14:0]   base;
    logic [PW-1:0] prod;
    base = a[14] ? (15'(QUARTER) - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    prod = PW'(base) * PW'(SINE_TABLE_ENTRIES);
    return prod[14 +: AW];
  endfunction

  // advance unless a finished word is held at the output
  assign en        = !v6_r || out_ready;
  assign in_ready  = en;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // lookup angles: sin and cos of polar, then of azimuth, per direction
  always_comb begin
    ang[0] = in_polar_u;
    ang[1] = in_polar_u + ANG_W'(QUARTER);
    ang[2] = in_azimuth_u;
    ang[3] = in_azimuth_u + ANG_W'(QUARTER);
    ang[4] = in_polar_v;
    ang[5] = in_polar_v + ANG_W'(QUARTER);
    ang[6] = in_azimuth_v;
    ang[7] = in_azimuth_v + ANG_W'(QUARTER);
  end

  // stage 1: table indexes, signs, squared resolutions
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 8; l++) begin
        idx_r[l]  <= quad_index(ang[l]);
        neg1_r[l] <= ang[l][ANG_W-1];
      end
      d2u1_r <= D2_W'(in_res_u) * D2_W'(in_res_u);
      d2v1_r <= D2_W'(in_res_v) * D2_W'(in_res_v);
    end
  end

  // stage 2: sine ROM reads
  for (genvar g = 0; g < 4; g++) begin : g_rom
    scx_sine_rom #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
      .AW(AW)
    ) u_rom (
      .clk(clk),
      .en(en),
      .addr_a(idx_r[2*g]),
      .addr_b(idx_r[2*g+1]),
      .data_a_r(ent[2*g]),
      .data_b_r(ent[2*g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg1_r;
      d2u2_r <= d2u1_r;
      d2v2_r <= d2v1_r;
    end
  end

  // apply quadrant sign
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      trig[l] = neg2_r[l] ? -signed'({1'b0, ent[l]}) : signed'({1'b0, ent[l]});
    end
  end

  // stage 3: unit vector components in Q2.30
  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        vec3_r[d][0] <= VEC_W'(trig[4*d]) * VEC_W'(trig[4*d+3]);
        vec3_r[d][1] <= VEC_W'(trig[4*d]) * VEC_W'(trig[4*d+2]);
        vec3_r[d][2] <= VEC_W'(trig[4*d+1]) <<< 15;
      end
      d2u3_r <= d2u2_r;
      d2v3_r <= d2v2_r;
    end
  end

  // stage 4: outer-product terms in Q60
  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 2; d++) begin
        for (int k = 0; k < NTERM; k++) begin
          pp4_r[d][k] <= PP_W'(vec3_r[d][ROW_IDX[k]]) * PP_W'(vec3_r[d][COL_IDX[k]]);
        end
      end
      d2u4_r <= d2u3_r;
      d2v4_r <= d2v3_r;
    end
  end

  // stages 5 and 6: weight by resolution squared and round
  for (genvar k = 0; k < NTERM; k++) begin : g_term
    scx_term u_term (
      .clk(clk),
      .en(en),
      .d2u(d2u4_r),
      .d2v(d2v4_r),
      .pu(pp4_r[0][k]),
      .pv(pp4_r[1][k]),
      .cov_r(cov[k])
    );
  end

  assign out_cov_xx = cov[0][DIAG_W-1:0];
  assign out_cov_yx = cov[1];
  assign out_cov_yy = cov[2][DIAG_W-1:0];
  assign out_cov_zx = cov[3];
  assign out_cov_zy = cov[4];
  assign out_cov_zz = cov[5][DIAG_W-1:0];
endmodule

// ===== rtl/scx_checker.sv =====
`timescale 1ns / 1ps
module scx_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [scx_pkg::DIAG_W-1:0] out_cov_xx
);
  // a held word stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a held word keeps its cov_xx value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cov_xx))
    else $error("output word changed while stalled");

  // input is taken exactly when the output side can move
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // reset empties the pipe
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind strip_covariance_to_xyz scx_checker u_scx_checker (.*);

// ===== tb/strip_covariance_to_xyz_tb.sv =====
`timescale 1ns / 1ps
module strip_covariance_to_xyz_tb;
  import scx_pkg::*;

  localparam int N_SINE = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef struct {
    logic [32:0] xx;
    logic [33:0] yx;
    logic [32:0] yy;
    logic [33:0] zx;
    logic [33:0] zy;
    logic [32:0] zz;
  } cov_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_res_u = '0, in_polar_u = '0, in_azimuth_u = '0;
  logic [15:0] in_res_v = '0, in_polar_v = '0, in_azimuth_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIAG_W-1:0] out_cov_xx, out_cov_yy, out_cov_zz;
  logic signed [COV_W-1:0] out_cov_yx, out_cov_zx, out_cov_zy;

  int fail_count = 0;
  int idle_pct = 28;
  int stall_cycles = 0;
  logic [63:0] sine_rom [0:N_SINE];

  always #5 clk = ~clk;

  strip_covariance_to_xyz #(.SINE_TABLE_ENTRIES(N_SINE)) u_top (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_res_u, .in_polar_u, .in_azimuth_u, .in_res_v, .in_polar_v, .in_azimuth_v,
    .out_valid, .out_ready,
    .out_cov_xx, .out_cov_yx, .out_cov_yy, .out_cov_zx, .out_cov_zy, .out_cov_zz
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Taylor series in Q30 rounded to Q15
  function automatic logic [63:0] sine_entry(input longint unsigned k);
    longint unsigned x, x2, term, acc;
    x = (k * HALF_PI_Q30) / N_SINE;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2) acc = acc - term;
      else acc = acc + term;
    end
    acc = (acc + 64'd16384) >> 15;
    if (acc > 32768) acc = 32768;
    return acc;
  endfunction

  function automatic longint lookup_sine(input logic [15:0] ang);
    longint unsigned idx;
    longint val;
    if (ang[14]) idx = ((64'd16384 - ang[13:0]) * N_SINE) >> 14;
    else idx = (64'(ang[13:0]) * N_SINE) >> 14;
    val = longint'(sine_sine_rom(idx));
    return ang[15] ? -val : val;
  endfunction

  function automatic logic [63:0] sine_sine_rom(input longint unsigned idx);
    return sine_rom[idx];
  endfunction

  function automatic logic signed [127:0] round_q60(input logic signed [127:0] v);
    return (v + (128'sd1 <<< 59)) >>> 60;
  endfunction

  // exact covariance in 128-bit arithmetic, rounded half up
  function automatic cov_word_t predict_cov(input logic [15:0] ru, pu, au, rv, pv, av);
    longint uvec [3], vvec [3];
    logic signed [127:0] d2u, d2v, t [6];
    int r [6] = '{0, 1, 1, 2, 2, 2};
    int c [6] = '{0, 0, 1, 0, 1, 2};
    cov_word_t w;
    uvec[0] = lookup_sine(pu) * lookup_sine(au + 16'd16384);
    uvec[1] = lookup_sine(pu) * lookup_sine(au);
    uvec[2] = lookup_sine(pu + 16'd16384) * 32768;
    vvec[0] = lookup_sine(pv) * lookup_sine(av + 16'd16384);
    vvec[1] = lookup_sine(pv) * lookup_sine(av);
    vvec[2] = lookup_sine(pv + 16'd16384) * 32768;
    d2u = 128'(ru) * 128'(ru);
    d2v = 128'(rv) * 128'(rv);
    for (int k = 0; k < 6; k++)
      t[k] = round_q60(d2u * (128'(uvec[r[k]]) * 128'(uvec[c[k]]))
                     + d2v * (128'(vvec[r[k]]) * 128'(vvec[c[k]])));
    w.xx = t[0][32:0]; w.yx = t[1][33:0]; w.yy = t[2][32:0];
    w.zx = t[3][33:0]; w.zy = t[4][33:0]; w.zz = t[5][32:0];
    return w;
  endfunction

  class cov_scoreboard;
    cov_word_t pending[$];

    function void note_input(cov_word_t w);
      pending = {pending, w};
    endfunction

    task check_output(cov_word_t got);
      cov_word_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got.xx, 0);
        return;
      end
      want = pending.pop_front();
      if (got.xx !== want.xx) report_mismatch("cov_xx", got.xx, want.xx);
      if (got.yx !== want.yx) report_mismatch("cov_yx", $signed(got.yx), $signed(want.yx));
      if (got.yy !== want.yy) report_mismatch("cov_yy", got.yy, want.yy);
      if (got.zx !== want.zx) report_mismatch("cov_zx", $signed(got.zx), $signed(want.zx));
      if (got.zy !== want.zy) report_mismatch("cov_zy", $signed(got.zy), $signed(want.zy));
      if (got.zz !== want.zz) report_mismatch("cov_zz", got.zz, want.zz);
    endtask
  endclass

  cov_scoreboard cov_sb = new();

  // drive one word, hold until accepted; drop valid only while idling
  task automatic send_word(input logic [15:0] ru, pu, au, rv, pv, av);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_res_u <= ru; in_polar_u <= pu; in_azimuth_u <= au;
    in_res_v <= rv; in_polar_v <= pv; in_azimuth_v <= av;
    do @(posedge clk); while (!in_ready);
    cov_sb.note_input(predict_cov(ru, pu, au, rv, pv, av));
  endtask

  // pick angles near quadrant boundaries often
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(3) == 0)
      return 16'(($urandom_range(3) << 14) + $urandom_range(8) - 4);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_res();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        cov_sb.check_output('{out_cov_xx, out_cov_yx, out_cov_yy,
                              out_cov_zx, out_cov_zy, out_cov_zz});
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] ang_pts [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                 16'hFFFF, 16'h3FFF, 16'h4001, 16'h2000};
    for (int k = 0; k <= N_SINE; k++) sine_rom[k] = sine_entry(k);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme resolutions, angles on and near quadrant boundaries, and a mixed word
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'hFFFF, 16'h4000, 16'h0000, 16'hFFFF, 16'h4000, 16'h4000);
    send_word(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_word(16'hFFFF, 16'h2000, 16'h2000, 16'hFFFF, 16'hE000, 16'hA000);
    for (int i = 0; i < 8; i++)
      send_word(16'hFFFF, ang_pts[i], ang_pts[(i + 3) % 8],
                16'h0001, ang_pts[(i + 5) % 8], ang_pts[i]);
    send_word(16'h8000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h5555, 16'hAAAA);
    in_valid <= 1'b0;

    // hold the sender until the pipe drains
    while (cov_sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int i = 0; i < 1850; i++) begin
      if (i == 600) idle_pct = 0;
      if (i == 900) idle_pct = 28;
      send_word(pick_res(), pick_angle(), pick_angle(),
                pick_res(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;

    while (cov_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
